### design/cc20_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and quarter-round helpers for the ChaCha20 block.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int WORD_W             = 32;
   localparam int WORDS              = 16;
   localparam int IDX_W              = 4;
   localparam int ITEM_WORDS         = 4;
   localparam int KEY_REGS           = 4;
   localparam int CSR_IDX_W          = 2;
   localparam int CSR_DATA_W         = 64;
   localparam int NUM_ROUNDS_DEFAULT = 20;

   typedef logic [WORD_W-1:0]            word_type;
   typedef logic [WORDS-1:0][WORD_W-1:0] block_type;

   // sigma constants, "expand 32-byte k", word 0 in the low slot
   localparam logic [3:0][WORD_W-1:0] SIGMA = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic mix;
      logic diagonal;
      logic second_half;
      logic finalize;
      logic shift;
   } dp_cmd_type;

   // the four words touched by one quarter round
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   // Half of a quarter round: the rotate-16/12 pair or the rotate-8/7 pair.
   function automatic quad_type qr_half(input quad_type q, input logic second);
      quad_type r;
      int       rot_x;
      int       rot_y;
      rot_x = second ? 8 : 16;
      rot_y = second ? 7 : 12;
      r     = q;
      r.a   = r.a + r.b;
      r.d   = rotl(r.d ^ r.a, rot_x);
      r.c   = r.c + r.d;
      r.b   = rotl(r.b ^ r.c, rot_y);
      return r;
   endfunction

endpackage
`default_nettype wire

### design/cc20_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_datapath
// Key registers, captured item, 16-word working state with four parallel
// half quarter rounds, final feed-forward add and the output shift line.
// ----------------------------------------------------------------------------
module cc20_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [cc20_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cc20_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_block_counter,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_0,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_1,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_2,
   input  wire cc20_pkg::dp_cmd_type             cmd,
   output logic      [cc20_pkg::WORD_W-1:0]      rsp_keystream_word
);
   import cc20_pkg::*;

   logic [CSR_DATA_W-1:0] key_ff  [KEY_REGS];
   word_type              item_ff [ITEM_WORDS];
   word_type              item_in [ITEM_WORDS];
   block_type             work_ff;
   block_type             work_in;
   block_type             init_load;
   block_type             init_hold;
   block_type             col_res;
   block_type             diag_res;

   // Initial state from key registers and an item.
   function automatic block_type build_init(input word_type it [ITEM_WORDS]);
      block_type s;
      for (int i = 0; i < 4; i++) begin
         s[i] = SIGMA[i];
      end
      for (int k = 0; k < KEY_REGS; k++) begin
         s[4 + 2*k] = key_ff[k][WORD_W-1:0];
         s[5 + 2*k] = key_ff[k][CSR_DATA_W-1:WORD_W];
      end
      for (int i = 0; i < ITEM_WORDS; i++) begin
         s[12 + i] = it[i];
      end
      return s;
   endfunction

   assign item_in[0] = req_block_counter;
   assign item_in[1] = req_nonce_word_0;
   assign item_in[2] = req_nonce_word_1;
   assign item_in[3] = req_nonce_word_2;

   always_comb begin
      init_load = build_init(item_in);
      init_hold = build_init(item_ff);
   end

   // Column and diagonal half rounds; four independent quarter rounds each.
   always_comb begin
      quad_type qc;
      quad_type qd;
      col_res  = work_ff;
      diag_res = work_ff;
      for (int q = 0; q < 4; q++) begin
         qc = qr_half({work_ff[q], work_ff[4 + q], work_ff[8 + q], work_ff[12 + q]},
                      cmd.second_half);
         col_res[q]      = qc.a;
         col_res[4 + q]  = qc.b;
         col_res[8 + q]  = qc.c;
         col_res[12 + q] = qc.d;
         qd = qr_half({work_ff[q], work_ff[4 + ((q + 1) % 4)],
                       work_ff[8 + ((q + 2) % 4)], work_ff[12 + ((q + 3) % 4)]},
                      cmd.second_half);
         diag_res[q]                 = qd.a;
         diag_res[4 + ((q + 1) % 4)] = qd.b;
         diag_res[8 + ((q + 2) % 4)] = qd.c;
         diag_res[12 + ((q + 3) % 4)] = qd.d;
      end
   end

   // Working state next value
   always_comb begin
      work_in = work_ff;
      priority if (cmd.load) begin
         work_in = init_load;
      end else if (cmd.mix) begin
         work_in = cmd.diagonal ? diag_res : col_res;
      end else if (cmd.finalize) begin
         for (int i = 0; i < WORDS; i++) begin
            work_in[i] = work_ff[i] + init_hold[i];
         end
      end else if (cmd.shift) begin
         work_in = work_ff >> WORD_W;
      end
   end

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_REGS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_write_enable) begin
         key_ff[csr_index] <= csr_write_data;
      end
   end

   // Captured item and working state
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         for (int i = 0; i < ITEM_WORDS; i++) begin
            item_ff[i] <= '0;
         end
      end else begin
         work_ff <= work_in;
         if (cmd.load) begin
            for (int i = 0; i < ITEM_WORDS; i++) begin
               item_ff[i] <= item_in[i];
            end
         end
      end
   end

   assign rsp_keystream_word = work_ff[0];

endmodule
`default_nettype wire

### design/cc20_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts an item, steps the half rounds, runs the final add and
// hands out the 16 keystream words.
// ----------------------------------------------------------------------------
module cc20_ctrl #(
   parameter int NUM_ROUNDS = cc20_pkg::NUM_ROUNDS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [cc20_pkg::IDX_W-1:0]   rsp_word_index,
   output logic                              rsp_last_word,
   output cc20_pkg::dp_cmd_type              cmd
);
   import cc20_pkg::*;

   localparam int STEPS  = 2 * NUM_ROUNDS;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
   localparam logic [IDX_W-1:0]  LAST_WORD = IDX_W'(WORDS - 1);

   state_type          state_ff;
   state_type          state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [IDX_W-1:0]   emit_ff;
   logic [IDX_W-1:0]   emit_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         emit_ff  <= emit_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      emit_in   = emit_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // step bit 0 picks the half, bit 1 the column/diagonal round
            cmd.mix         = 1'b1;
            cmd.second_half = step_ff[0];
            cmd.diagonal    = step_ff[1];
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINAL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            emit_in      = '0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (emit_ff == LAST_WORD) begin
                  emit_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = emit_ff;
   assign rsp_last_word  = (emit_ff == LAST_WORD);

endmodule
`default_nettype wire

### design/chacha20_block_function.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_block_function
// ChaCha20 block function: one 16-word keystream block per request.
// ----------------------------------------------------------------------------
// The 256-bit key sits in four 64-bit registers written through the csr port
// (index i holds key words 2i in the low half and 2i+1 in the high half).
// Each request transfer carries the block counter and three nonce words; the
// block answers with 16 response transfers, word_index 0 to 15, last_word set
// on the final one. The mixing datapath performs half of each of the four
// parallel quarter rounds per cycle and steps through all of the half rounds
// before the feed-forward add; the response words follow it. A new request
// is taken once the last word of the previous block has been transferred.
// ----------------------------------------------------------------------------
module chacha20_block_function #(
   parameter int NUM_ROUNDS = cc20_pkg::NUM_ROUNDS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [cc20_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cc20_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_block_counter,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_0,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_1,
   input  wire logic [cc20_pkg::WORD_W-1:0]      req_nonce_word_2,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [cc20_pkg::WORD_W-1:0]      rsp_keystream_word,
   output logic      [cc20_pkg::IDX_W-1:0]       rsp_word_index,
   output logic                                  rsp_last_word
);
   import cc20_pkg::*;

   dp_cmd_type cmd;

   cc20_ctrl #(
      .NUM_ROUNDS (NUM_ROUNDS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   cc20_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_block_counter  (req_block_counter),
      .req_nonce_word_0   (req_nonce_word_0),
      .req_nonce_word_1   (req_nonce_word_1),
      .req_nonce_word_2   (req_nonce_word_2),
      .cmd                (cmd),
      .rsp_keystream_word (rsp_keystream_word)
   );

endmodule
`default_nettype wire

### tb/sv/chacha20_block_function_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chacha20_block_function_tb
// Self-checking testbench for the ChaCha20 keystream block.
// ----------------------------------------------------------------------------
// Each request transfer is mirrored into a predictor that builds the 16-word
// state from sigma, the current key, counter and nonce, mixes it and adds the
// initial state back. The 16 expected words are queued and every response
// transfer is checked in order against them. Keys are changed only while the
// block is idle. Directed blocks cover zero, all-ones and alternating patterns
// and the well-known published vector; random blocks follow under several
// keys with random gaps on both sides and two long response hold-offs.
// ----------------------------------------------------------------------------
module chacha20_block_function_tb;
   import cc20_pkg::*;

   localparam int ROUNDS       = NUM_ROUNDS_DEFAULT;
   localparam int DRAIN_CYCLES = 2 * ROUNDS + 24;
   localparam int CYCLE_LIMIT  = 600_000;
   localparam int RANDOM_SETS  = 10;
   localparam int SET_BLOCKS   = 50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_0,
      CSR_KEY_1,
      CSR_KEY_2,
      CSR_KEY_3
   } key_reg_type;

   typedef struct packed {
      word_type   word;
      logic [3:0] index;
      logic       last;
   } keystream_beat_type;

   // ------------------------------------------------------------------------
   // Keystream predictor and checker
   // ------------------------------------------------------------------------
   class keystream_board;
      int                 rounds;
      word_type           key_words [8];
      word_type           mix [16];
      keystream_beat_type words_due [$];
      int                 mismatches;

      function new(int num_rounds);
         rounds     = num_rounds;
         mismatches = 0;
         foreach (key_words[i]) key_words[i] = '0;
      endfunction

      function void set_key(key_reg_type reg_idx, logic [CSR_DATA_W-1:0] value);
         int slot;
         slot                = 2 * int'(reg_idx);
         key_words[slot]     = value[31:0];
         key_words[slot + 1] = value[63:32];
      endfunction

      function word_type rot_left(word_type v, int n);
         return (v << n) | (v >> (WORD_W - n));
      endfunction

      function void quarter(int a, int b, int c, int d);
         mix[a] = mix[a] + mix[b];
         mix[d] = rot_left(mix[d] ^ mix[a], 16);
         mix[c] = mix[c] + mix[d];
         mix[b] = rot_left(mix[b] ^ mix[c], 12);
         mix[a] = mix[a] + mix[b];
         mix[d] = rot_left(mix[d] ^ mix[a], 8);
         mix[c] = mix[c] + mix[d];
         mix[b] = rot_left(mix[b] ^ mix[c], 7);
      endfunction

      // request transfer accepted: queue the 16 words it must produce
      function void note_block(word_type counter, word_type n0, word_type n1,
                               word_type n2);
         word_type           init [16];
         keystream_beat_type beat;
         for (int i = 0; i < 4; i++) init[i] = SIGMA[i];
         for (int i = 0; i < 8; i++) init[4 + i] = key_words[i];
         init[12] = counter;
         init[13] = n0;
         init[14] = n1;
         init[15] = n2;
         mix = init;
         // even rounds mix columns, odd rounds mix diagonals
         for (int r = 0; r < rounds; r++) begin
            if (r % 2 == 0) begin
               quarter(0, 4, 8, 12);
               quarter(1, 5, 9, 13);
               quarter(2, 6, 10, 14);
               quarter(3, 7, 11, 15);
            end else begin
               quarter(0, 5, 10, 15);
               quarter(1, 6, 11, 12);
               quarter(2, 7, 8, 13);
               quarter(3, 4, 9, 14);
            end
         end
         for (int i = 0; i < WORDS; i++) begin
            beat.word  = mix[i] + init[i];
            beat.index = i[3:0];
            beat.last  = (i == WORDS - 1);
            words_due.push_back(beat);
         end
      endfunction

      // response transfer seen: compare with the oldest queued word
      function void check_word(word_type word, logic [3:0] index, logic last);
         keystream_beat_type want;
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected word %h index %0d last %b", word, index, last);
            return;
         end
         want = words_due.pop_front();
         if (want.word !== word || want.index !== index || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: word exp %h/%0d/%b got %h/%0d/%b",
                        want.word, want.index, want.last, word, index, last);
         end
      endfunction

      function int pending();
         return words_due.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals and DUT
   // ------------------------------------------------------------------------
   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   csr_write_enable   = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data     = '0;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   word_type               req_block_counter  = '0;
   word_type               req_nonce_word_0   = '0;
   word_type               req_nonce_word_1   = '0;
   word_type               req_nonce_word_2   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   word_type               rsp_keystream_word;
   logic [IDX_W-1:0]       rsp_word_index;
   logic                   rsp_last_word;

   logic                   hold_off           = 1'b0;
   int                     req_quiet          = 0;
   int                     rsp_quiet          = 0;
   int                     cycle_count        = 0;
   keystream_board         board;

   chacha20_block_function #(
      .NUM_ROUNDS(ROUNDS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_block_counter  (req_block_counter),
      .req_nonce_word_0   (req_nonce_word_0),
      .req_nonce_word_1   (req_nonce_word_1),
      .req_nonce_word_2   (req_nonce_word_2),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------
   // idle cycles before a transfer; now and then a run with no idling at all
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet = $urandom_range(5, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // random word biased toward the corners
   function automatic word_type pick_word();
      word_type one_hot;
      one_hot = word_type'(1) << $urandom_range(0, WORD_W - 1);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_key_reg();
      return {pick_word(), pick_word()};
   endfunction

   task automatic write_csr(input key_reg_type reg_idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_key(reg_idx, data);
   endtask

   task automatic write_key(input logic [CSR_DATA_W-1:0] k0, input logic [CSR_DATA_W-1:0] k1,
                            input logic [CSR_DATA_W-1:0] k2, input logic [CSR_DATA_W-1:0] k3);
      write_csr(CSR_KEY_0, k0);
      write_csr(CSR_KEY_1, k1);
      write_csr(CSR_KEY_2, k2);
      write_csr(CSR_KEY_3, k3);
   endtask

   // one request transfer, after a random number of idle cycles
   task automatic send_block(input word_type counter, input word_type n0,
                             input word_type n1, input word_type n2);
      int gap;
      gap = draw_gap(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_block_counter <= counter;
      req_nonce_word_0  <= n0;
      req_nonce_word_1  <= n1;
      req_nonce_word_2  <= n2;
      do @(posedge clock); while (!req_ready);
      board.note_block(counter, n0, n1, n2);
   endtask

   // stop offering, wait for every queued word, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, checked at the rising edge
   // ------------------------------------------------------------------------
   initial begin
      int rsp_wait;
      rsp_wait = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            board.check_word(rsp_keystream_word, rsp_word_index, rsp_last_word);
            rsp_wait = draw_gap(rsp_quiet);
         end
      end
   end

   // long response hold-offs so the block backs up into the request side
   initial begin
      wait (reset == 1'b0);
      repeat (9000) @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
      repeat (25000) @(posedge clock);
      hold_off = 1'b1;
      repeat (700) @(posedge clock);
      hold_off = 1'b0;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      board = new(ROUNDS);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // key still zero from reset
      send_block('0, '0, '0, '0);
      send_block('1, '1, '1, '1);
      send_block(32'hffffffff, '0, '0, '0);
      send_block(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
      send_block(32'h00000001, 32'h80000000, 32'h00000001, 32'h80000000);
      settle();

      // all-ones key
      write_key('1, '1, '1, '1);
      send_block('0, '0, '0, '0);
      send_block('1, '1, '1, '1);
      send_block(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
      send_block(32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001);
      settle();

      // published test vector: key bytes 00..1f, counter 1
      write_key(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
                64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918);
      send_block(32'h00000001, 32'h09000000, 32'h4a000000, 32'h00000000);
      send_block(32'h00000001, 32'h00000000, 32'h4a000000, 32'h00000000);
      send_block(32'hfffffffe, 32'h00000000, 32'h00000000, 32'h00000001);
      settle();

      // alternating key halves
      write_key(64'haaaaaaaa_55555555, 64'h55555555_aaaaaaaa,
                64'h00000000_ffffffff, 64'hffffffff_00000000);
      send_block('0, '1, '0, '1);
      send_block('1, '0, '1, '0);
      send_block(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      settle();

      // random blocks under a fresh key each set
      for (int s = 0; s < RANDOM_SETS; s++) begin
         write_key(pick_key_reg(), pick_key_reg(), pick_key_reg(), pick_key_reg());
         for (int n = 0; n < SET_BLOCKS; n++)
            send_block(pick_word(), pick_word(), pick_word(), pick_word());
         settle();
      end

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
